FILE: sv/trsg_pkg.sv
package trsg_pkg;

  typedef enum logic [2:0] {
    PH_INIT = 3'd0,
    PH_RISE = 3'd1,
    PH_FALL = 3'd2,
    PH_RET  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  localparam int unsigned PHASE_WIDTH = 3;
  localparam int unsigned CFG_INDEX_WIDTH = 3;

endpackage

FILE: sv/trsg_cfg_regs.sv
module trsg_cfg_regs
  import trsg_pkg::*;
#(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned CFG_WIDTH   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0]  wr_index,
  input  logic [CFG_WIDTH-1:0]        wr_data,
  output logic signed [POS_WIDTH-1:0] upper_limit,
  output logic signed [POS_WIDTH-1:0] lower_limit,
  output logic signed [POS_WIDTH-1:0] start_value,
  output logic signed [POS_WIDTH-1:0] end_value,
  output logic signed [POS_WIDTH-1:0] step,
  output logic [COUNT_WIDTH-1:0]      cycle_count
);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_UPPER_LIMIT = 3'd0,
    REG_LOWER_LIMIT = 3'd1,
    REG_START_VALUE = 3'd2,
    REG_END_VALUE   = 3'd3,
    REG_STEP        = 3'd4,
    REG_CYCLE_COUNT = 3'd5
  } reg_index_t;

  // 1.0 in the position format
  localparam logic [POS_WIDTH-1:0] UPPER_RESET = POS_WIDTH'(65'd1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_RESET;
      lower_limit <= '0;
      start_value <= '0;
      end_value   <= '0;
      step        <= '0;
      cycle_count <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_UPPER_LIMIT: upper_limit <= wr_data[POS_WIDTH-1:0];
        REG_LOWER_LIMIT: lower_limit <= wr_data[POS_WIDTH-1:0];
        REG_START_VALUE: start_value <= wr_data[POS_WIDTH-1:0];
        REG_END_VALUE:   end_value   <= wr_data[POS_WIDTH-1:0];
        REG_STEP:        step        <= wr_data[POS_WIDTH-1:0];
        REG_CYCLE_COUNT: cycle_count <= wr_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/trsg_step.sv
module trsg_step
  import trsg_pkg::*;
#(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        restart,
  input  logic signed [POS_WIDTH-1:0] position,
  input  phase_t                      phase,
  input  logic [COUNT_WIDTH:0]        count,
  input  logic signed [POS_WIDTH-1:0] upper_limit,
  input  logic signed [POS_WIDTH-1:0] lower_limit,
  input  logic signed [POS_WIDTH-1:0] start_value,
  input  logic signed [POS_WIDTH-1:0] end_value,
  input  logic signed [POS_WIDTH-1:0] step,
  input  logic [COUNT_WIDTH-1:0]      cycle_count,
  output logic signed [POS_WIDTH-1:0] position_next,
  output phase_t                      phase_next,
  output logic [COUNT_WIDTH:0]        count_next
);

  localparam int unsigned W = POS_WIDTH;
  localparam logic signed [W+1:0] SUM_MAX = (W+2)'((65'd1 << (W-1)) - 65'd1);
  localparam logic signed [W+1:0] SUM_MIN = ~SUM_MAX;

  logic signed [W:0]   st_ext;
  logic signed [W:0]   st_neg;
  logic signed [W:0]   st_abs;
  logic signed [W:0]   delta;
  logic signed [W+1:0] sum;
  logic signed [W-1:0] moved;
  logic [COUNT_WIDTH:0] count_inc;
  logic                 st_pos;
  logic                 st_negative;
  logic                 st_zero;

  assign st_ext      = {step[W-1], step};
  assign st_neg      = -st_ext;
  assign st_abs      = step[W-1] ? st_neg : st_ext;
  assign st_negative = step[W-1];
  assign st_zero     = (step == '0);
  assign st_pos      = !st_negative && !st_zero;

  // one shared saturating adder, operand picked by phase
  always_comb begin
    case (phase)
      PH_INIT: delta = st_ext;
      PH_RISE: delta = st_abs;
      PH_FALL: delta = -st_abs;
      PH_RET:  delta = st_neg;
      default: delta = '0;
    endcase
  end

  assign sum = {position[W-1], position[W-1], position} + {delta[W], delta};

  always_comb begin
    if (sum > SUM_MAX) begin
      moved = SUM_MAX[W-1:0];
    end else if (sum < SUM_MIN) begin
      moved = SUM_MIN[W-1:0];
    end else begin
      moved = sum[W-1:0];
    end
  end

  assign count_inc = (count == '1) ? count : count + 1'b1;

  always_comb begin
    position_next = position;
    phase_next    = phase;
    count_next    = count;
    if (restart) begin
      position_next = start_value;
      phase_next    = PH_INIT;
      count_next    = '0;
    end else begin
      case (phase)
        PH_INIT: begin
          position_next = moved;
          if (moved <= lower_limit) begin
            phase_next = PH_RISE;
            count_next = count_inc;
          end else if (moved >= upper_limit) begin
            phase_next = PH_FALL;
            count_next = count_inc;
          end
        end
        PH_FALL: begin
          position_next = moved;
          if (moved <= lower_limit) begin
            // zero step counts as falling
            count_next = !st_pos ? count_inc : count;
            phase_next = ((!st_pos ? count_inc : count) > {1'b0, cycle_count}) ? PH_RET
                                                                               : PH_RISE;
          end
        end
        PH_RISE: begin
          position_next = moved;
          if (moved >= upper_limit) begin
            count_next = st_pos ? count_inc : count;
            phase_next = ((st_pos ? count_inc : count) > {1'b0, cycle_count}) ? PH_RET
                                                                              : PH_FALL;
          end
        end
        PH_RET: begin
          position_next = moved;
          if ((st_pos && moved < end_value) || (st_negative && moved > end_value)) begin
            phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/triangle_ramp_setpoint_generator.sv
// result: registered; it appears on the master side in the cycle after an accepted item
// throughput: one item per cycle while m_tready is high; the state registers double as the result register
// and s_tready stays high while the result is taken in the same cycle
// reset: synchronous, active high; position 0, initial phase, count 0,
// upper_limit 1.0 and all other registers 0
module triangle_ramp_setpoint_generator
  import trsg_pkg::*;
#(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_WIDTH = 16,
  localparam int unsigned CFG_WIDTH  = (POS_WIDTH > COUNT_WIDTH) ? POS_WIDTH : COUNT_WIDTH,
  localparam int unsigned OUT_WIDTH  = ((POS_WIDTH + PHASE_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,    // restart
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_WIDTH-1:0]       m_tdata,    // position, phase
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  logic signed [POS_WIDTH-1:0] upper_limit;
  logic signed [POS_WIDTH-1:0] lower_limit;
  logic signed [POS_WIDTH-1:0] start_value;
  logic signed [POS_WIDTH-1:0] end_value;
  logic signed [POS_WIDTH-1:0] step;
  logic [COUNT_WIDTH-1:0]      cycle_count;

  logic signed [POS_WIDTH-1:0] position_reg;
  logic signed [POS_WIDTH-1:0] position_next;
  phase_t                      phase_reg;
  phase_t                      phase_next;
  logic [COUNT_WIDTH:0]        crossing_count;
  logic [COUNT_WIDTH:0]        crossing_count_next;
  logic                        accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  trsg_cfg_regs #(
    .POS_WIDTH   (POS_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .CFG_WIDTH   (CFG_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .upper_limit (upper_limit),
    .lower_limit (lower_limit),
    .start_value (start_value),
    .end_value   (end_value),
    .step        (step),
    .cycle_count (cycle_count)
  );

  trsg_step #(
    .POS_WIDTH   (POS_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .restart       (s_tdata[0]),
    .position      (position_reg),
    .phase         (phase_reg),
    .count         (crossing_count),
    .upper_limit   (upper_limit),
    .lower_limit   (lower_limit),
    .start_value   (start_value),
    .end_value     (end_value),
    .step          (step),
    .cycle_count   (cycle_count),
    .position_next (position_next),
    .phase_next    (phase_next),
    .count_next    (crossing_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= '0;
      phase_reg      <= PH_INIT;
      crossing_count <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        position_reg   <= position_next;
        phase_reg      <= phase_next;
        crossing_count <= crossing_count_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = OUT_WIDTH'({phase_reg, position_reg});

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tdata[0] |=> m_tvalid && phase_reg == PH_INIT && crossing_count == '0)
    else $error("restart item did not clear phase and count");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tdata[0] && phase_reg == PH_DONE
      |=> phase_reg == PH_DONE && position_reg == $past(position_reg))
    else $error("done phase moved without restart");

  a_return_no_bounce: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tdata[0] && phase_reg == PH_RET |=> phase_reg == PH_RET || phase_reg == PH_DONE)
    else $error("return phase went back to bouncing");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tdata[0] |=> crossing_count >= $past(crossing_count))
    else $error("crossing count decreased without restart");

  a_state_stable_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(position_reg) && $stable(phase_reg) && $stable(crossing_count))
    else $error("state changed without an accepted item");

endmodule
